// File: hdl/yuv420_rotate_address_generator_macros.svh
// Assertion helpers for the address generator sequencer module
`ifndef YUV420_ROTATE_ADDRESS_GENERATOR_MACROS_SVH
`define YUV420_ROTATE_ADDRESS_GENERATOR_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define YRA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted
`define YRA_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/yra_pkg.sv
package yra_pkg;

  // Frame dimension and offset widths
  localparam int DIM_BITS     = 13;
  localparam int OFS_BITS     = 26;
  localparam int CFG_IDX_BITS = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_LAYOUT   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROTATION = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CROP_W   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CROP_H   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STRIDE   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PITCH    = 3'd5;

  // Rotation codes
  localparam logic [1:0] ROT_90  = 2'd0;
  localparam logic [1:0] ROT_180 = 2'd1;
  localparam logic [1:0] ROT_270 = 2'd2;
  localparam logic [1:0] ROT_BAD = 2'd3;

  // Chroma layouts: the first planar code and everything above it is planar
  localparam logic [1:0] LAYOUT_NV12 = 2'd0;
  localparam logic [1:0] LAYOUT_YV12 = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_BADROT = 2'd2;

  // Plane codes
  localparam logic PLANE_LUMA   = 1'b0;
  localparam logic PLANE_CHROMA = 1'b1;

  typedef struct packed {
    logic [1:0]          layout;
    logic [1:0]          rotation;
    logic [DIM_BITS-1:0] vis_width;
    logic [DIM_BITS-1:0] vis_height;
    logic [DIM_BITS-1:0] line_stride;
    logic [DIM_BITS-1:0] rotated_pitch;
  } yra_cfg_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] olim;
    logic [DIM_BITS-1:0] ilim;
  } yra_lim_t;

  // Operands for the offset stage: src = s_fac * s_mul + s_add,
  // dst = d_fac * d_mul + d_add, all modulo 2^OFS_BITS
  typedef struct packed {
    logic [1:0]          status;
    logic                plane;
    logic                last;
    logic [OFS_BITS-1:0] s_fac;
    logic [DIM_BITS-1:0] s_mul;
    logic [OFS_BITS-1:0] s_add;
    logic [DIM_BITS-1:0] d_fac;
    logic [DIM_BITS-1:0] d_mul;
    logic [OFS_BITS-1:0] d_add;
  } yra_op_t;

  // Zero-extend a dimension to offset width
  function automatic logic [OFS_BITS-1:0] ofs_ext(input logic [DIM_BITS-1:0] v);
    return {{(OFS_BITS-DIM_BITS){1'b0}}, v};
  endfunction

  // Loop limits of one plane; crop sizes rounded down to even
  function automatic yra_lim_t loop_limits(input yra_cfg_t cfg, input logic chroma);
    logic [DIM_BITS-1:0] pw;
    logic [DIM_BITS-1:0] ph;
    yra_lim_t            lim;
    pw = {cfg.vis_width[DIM_BITS-1:1], 1'b0};
    ph = {cfg.vis_height[DIM_BITS-1:1], 1'b0};
    if (chroma) begin
      pw = pw >> 1;
      ph = ph >> 1;
    end
    if (cfg.rotation == ROT_180) begin
      lim.olim = ph;
      lim.ilim = pw;
    end else begin
      lim.olim = pw;
      lim.ilim = ph;
    end
    return lim;
  endfunction

endpackage

// File: hdl/yra_seq.sv
`include "yuv420_rotate_address_generator_macros.svh"

module yra_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  yra_pkg::yra_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_start_req,
  output logic              op_valid,
  input  logic              op_ready,
  output yra_pkg::yra_op_t  op
);
  import yra_pkg::*;

  logic                busy_r, busy_nxt;
  logic                phase_r, phase_nxt;
  logic [DIM_BITS-1:0] outer_r, outer_nxt;
  logic [DIM_BITS-1:0] inner_r, inner_nxt;
  logic                op_valid_r, op_valid_nxt;
  yra_op_t             op_r, op_nxt;

  logic                in_acc;
  yra_lim_t            lim_luma, lim_chroma, lim_cur;
  logic                cur_busy, cur_phase;
  logic [DIM_BITS-1:0] cur_o, cur_n;
  logic [DIM_BITS:0]   o_inc, n_inc;
  logic                planar;
  logic [DIM_BITS-1:0] pw, ph, phc, cs, pwc, uva_base, uva;
  logic [OFS_BITS-1:0] o_x, n_x, o1_u, n1_u;

  // Shorthands for the checks at the end
  logic                bad_hit, bad_done, last_hit, last_done, op_not_ok, op_blank;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = !op_valid_r || op_ready;
  assign op_valid = op_valid_r;
  assign op       = op_r;

  assign lim_luma   = loop_limits(cfg, PLANE_LUMA);
  assign lim_chroma = loop_limits(cfg, PLANE_CHROMA);

  // Geometry shared by the operand selection
  assign planar   = cfg.layout >= LAYOUT_YV12;
  assign pw       = {cfg.vis_width[DIM_BITS-1:1], 1'b0};
  assign ph       = {cfg.vis_height[DIM_BITS-1:1], 1'b0};
  assign phc      = ph >> 1;
  assign cs       = planar ? (cfg.line_stride >> 1) : cfg.line_stride;
  assign pwc      = planar ? (pw >> 1) : pw;
  assign uva_base = (cfg.rotation == ROT_180) ? cfg.line_stride : cfg.rotated_pitch;
  assign uva      = planar ? (uva_base >> 1) : uva_base;

  // Step the transfer and form the operands of the copy it emits
  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    outer_nxt = outer_r;
    inner_nxt = inner_r;
    cur_busy  = busy_r;
    cur_phase = phase_r;
    cur_o     = outer_r;
    cur_n     = inner_r;
    op_nxt        = '0;
    op_nxt.status = ST_IDLE;

    if (cfg.rotation == ROT_BAD && (in_start_req || busy_r)) begin
      op_nxt.status = ST_BADROT;
      busy_nxt      = 1'b0;
      cur_busy      = 1'b0;
    end else if (in_start_req) begin
      cur_phase = PLANE_LUMA;
      cur_o     = '0;
      cur_n     = '0;
      cur_busy  = (lim_luma.olim != '0) && (lim_luma.ilim != '0);
    end

    lim_cur = cur_phase ? lim_chroma : lim_luma;
    o_inc   = {1'b0, cur_o} + 1'b1;
    n_inc   = {1'b0, cur_n} + 1'b1;
    o_x     = ofs_ext(cur_o);
    n_x     = ofs_ext(cur_n);
    o1_u    = planar ? (o_x + OFS_BITS'(1)) : ((o_x + OFS_BITS'(1)) << 1);
    n1_u    = planar ? (n_x + OFS_BITS'(1)) : ((n_x + OFS_BITS'(1)) << 1);

    if (cur_busy) begin
      op_nxt.status = ST_OK;
      op_nxt.plane  = cur_phase;
      op_nxt.d_fac  = cur_o;
      busy_nxt      = 1'b1;
      phase_nxt     = cur_phase;
      outer_nxt     = cur_o;

      // Operands per plane and rotation
      if (cur_phase == PLANE_LUMA) begin
        op_nxt.s_mul = cfg.line_stride;
        op_nxt.d_add = n_x;
        op_nxt.d_mul = (cfg.rotation == ROT_180) ? cfg.line_stride : cfg.rotated_pitch;
        case (cfg.rotation)
          ROT_90: begin
            op_nxt.s_fac = n_x;
            op_nxt.s_add = ofs_ext(pw) - OFS_BITS'(1) - o_x;
          end
          ROT_180: begin
            op_nxt.s_fac = ofs_ext(ph) - OFS_BITS'(1) - o_x;
            op_nxt.s_add = ofs_ext(pw) - OFS_BITS'(1) - n_x;
          end
          default: begin
            op_nxt.s_fac = ofs_ext(ph) - OFS_BITS'(1) - n_x;
            op_nxt.s_add = o_x;
          end
        endcase
      end else begin
        op_nxt.s_mul = cs;
        op_nxt.d_mul = uva;
        op_nxt.d_add = planar ? n_x : (n_x << 1);
        case (cfg.rotation)
          ROT_90: begin
            op_nxt.s_fac = n_x;
            op_nxt.s_add = ofs_ext(pwc) - o1_u;
          end
          ROT_180: begin
            op_nxt.s_fac = ofs_ext(phc) - OFS_BITS'(1) - o_x;
            op_nxt.s_add = ofs_ext(pwc) - n1_u;
          end
          default: begin
            op_nxt.s_fac = ofs_ext(phc) - OFS_BITS'(1) - n_x;
            op_nxt.s_add = planar ? o_x : (o_x << 1);
          end
        endcase
      end

      // Advance the counters to the next copy
      if (n_inc < {1'b0, lim_cur.ilim}) begin
        inner_nxt = n_inc[DIM_BITS-1:0];
      end else begin
        inner_nxt = '0;
        if (o_inc < {1'b0, lim_cur.olim}) begin
          outer_nxt = o_inc[DIM_BITS-1:0];
        end else begin
          outer_nxt = '0;
          if (cur_phase == PLANE_LUMA && lim_chroma.olim != '0 && lim_chroma.ilim != '0) begin
            phase_nxt = PLANE_CHROMA;
          end else begin
            busy_nxt    = 1'b0;
            phase_nxt   = PLANE_LUMA;
            op_nxt.last = 1'b1;
          end
        end
      end
    end else if (in_start_req && op_nxt.status != ST_BADROT) begin
      // Empty frame: restart clears the counters and stays idle
      busy_nxt  = 1'b0;
      phase_nxt = PLANE_LUMA;
      outer_nxt = '0;
      inner_nxt = '0;
    end
  end

  // Hold the operand register until the offset stage takes it
  always_comb begin
    if (in_acc) begin
      op_valid_nxt = 1'b1;
    end else if (op_ready) begin
      op_valid_nxt = 1'b0;
    end else begin
      op_valid_nxt = op_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      phase_r    <= PLANE_LUMA;
      outer_r    <= '0;
      inner_r    <= '0;
      op_valid_r <= 1'b0;
    end else begin
      op_valid_r <= op_valid_nxt;
      if (in_acc) begin
        busy_r  <= busy_nxt;
        phase_r <= phase_nxt;
        outer_r <= outer_nxt;
        inner_r <= inner_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= op_nxt;
    end
  end

  // A bad rotation only reports on a start or while a frame is running
  assign bad_hit   = in_acc && cfg.rotation == ROT_BAD && (in_start_req || busy_r);
  assign bad_done  = op_valid_r && op_r.status == ST_BADROT && !busy_r;
  assign last_hit  = in_acc && op_nxt.last;
  assign last_done = !busy_r && phase_r == PLANE_LUMA && op_r.status == ST_OK;
  assign op_not_ok = op_valid_r && op_r.status != ST_OK;
  assign op_blank  = op_r.s_fac == '0 && op_r.d_fac == '0 && op_r.s_add == '0 &&
                     op_r.d_add == '0 && !op_r.last && !op_r.plane;

  `YRA_ASSERT_NXT(a_bad_rot_stops, clk, rst_n, bad_hit, bad_done, "bad rotation left it busy")
  `YRA_ASSERT_NXT(a_last_ends_frame, clk, rst_n, last_hit, last_done, "final copy left it busy")
  `YRA_ASSERT_IMP(a_blank_non_ok, clk, rst_n, op_not_ok, op_blank, "non-ok request has operands")

endmodule

// File: hdl/yra_ofs.sv
module yra_ofs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              op_valid,
  output logic                              op_ready,
  input  yra_pkg::yra_op_t                  op,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic                              out_plane,
  output logic [yra_pkg::OFS_BITS-1:0]      out_src_offset,
  output logic [yra_pkg::OFS_BITS-1:0]      out_dst_offset,
  output logic                              out_last
);
  import yra_pkg::*;

  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   status_r;
  logic                         plane_r, last_r;
  logic [OFS_BITS-1:0]          src_r, src_nxt;
  logic [OFS_BITS-1:0]          dst_r, dst_nxt;
  logic [OFS_BITS+DIM_BITS-1:0] s_prod;
  logic [2*DIM_BITS-1:0]        d_prod;
  logic                         op_take;

  assign op_ready = !out_valid_r || out_ready;
  assign op_take  = op_valid && op_ready;

  // Multiply and add, wrapping at offset width
  assign s_prod  = op.s_fac * op.s_mul;
  assign d_prod  = op.d_fac * op.d_mul;
  assign src_nxt = s_prod[OFS_BITS-1:0] + op.s_add;
  assign dst_nxt = OFS_BITS'(d_prod) + op.d_add;

  // Hold the result until the receiver takes it
  always_comb begin
    if (op_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_take) begin
      status_r <= op.status;
      plane_r  <= op.plane;
      last_r   <= op.last;
      src_r    <= src_nxt;
      dst_r    <= dst_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_plane      = plane_r;
  assign out_src_offset = src_r;
  assign out_dst_offset = dst_r;
  assign out_last       = last_r;

endmodule

// File: hdl/yuv420_rotate_address_generator.sv
// Source/destination offset generator for rotating a 4:2:0 frame.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high and a register takes cfg_data at the accepting edge.
// Write registers only while no request is in flight.
// Request channel: in_valid/in_ready with in_start_req. A request with
// in_start_req high restarts the frame at its first copy; a low one
// advances by one copy. Every request yields exactly one result.
// Result channel: out_valid/out_ready with status, plane, both offsets and
// last (high on the final copy of the frame).
// Pipeline: the sequencer register loads at the accepting edge, and the
// multiply-add result register loads when the offset stage takes the
// operands; out_valid rises with that result register.
// Throughput: one request per cycle while out_ready is high.
// Reset: configuration and sequencer state clear to zero, no request or
// result is held, and the generator is idle.
// Stall: when out_ready is low the result holds, the sequencer stage fills,
// and in_ready falls; nothing is dropped and no state advances.
module yuv420_rotate_address_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [yra_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [yra_pkg::DIM_BITS-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_start_req,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic                                out_plane,
  output logic [yra_pkg::OFS_BITS-1:0]        out_src_offset,
  output logic [yra_pkg::OFS_BITS-1:0]        out_dst_offset,
  output logic                                out_last
);
  import yra_pkg::*;

  yra_cfg_t cfg_r, cfg_nxt;
  yra_op_t  op;
  logic     op_valid, op_ready;

  assign cfg_ready = 1'b1;

  // Decode register writes; unknown indexes drop
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LAYOUT:   cfg_nxt.layout        = cfg_data[1:0];
        CFG_ROTATION: cfg_nxt.rotation      = cfg_data[1:0];
        CFG_CROP_W:   cfg_nxt.vis_width     = cfg_data;
        CFG_CROP_H:   cfg_nxt.vis_height    = cfg_data;
        CFG_STRIDE:   cfg_nxt.line_stride   = cfg_data;
        CFG_PITCH:    cfg_nxt.rotated_pitch = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  yra_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_start_req (in_start_req),
    .op_valid     (op_valid),
    .op_ready     (op_ready),
    .op           (op)
  );

  yra_ofs u_ofs (
    .clk            (clk),
    .rst_n          (rst_n),
    .op_valid       (op_valid),
    .op_ready       (op_ready),
    .op             (op),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_plane      (out_plane),
    .out_src_offset (out_src_offset),
    .out_dst_offset (out_dst_offset),
    .out_last       (out_last)
  );

endmodule

// File: dv/yra_copy_checker.sv
`timescale 1ns / 100ps

module yra_copy_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [yra_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [yra_pkg::DIM_BITS-1:0]     cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             in_start_req,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [1:0]                       out_status,
  input  logic                             out_plane,
  input  logic [yra_pkg::OFS_BITS-1:0]     out_src_offset,
  input  logic [yra_pkg::OFS_BITS-1:0]     out_dst_offset,
  input  logic                             out_last,
  output int                               fail_count,
  output int                               copies_pending
);

  import yra_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]          status;
    logic                plane;
    logic [OFS_BITS-1:0] src;
    logic [OFS_BITS-1:0] dst;
    logic                last;
  } rot_copy_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] outer_lim;
    logic [DIM_BITS-1:0] inner_lim;
  } walk_lim_t;

  // Register copy
  logic [1:0]          layout_q;
  logic [1:0]          rot_q;
  logic [DIM_BITS-1:0] crop_w_q;
  logic [DIM_BITS-1:0] crop_h_q;
  logic [DIM_BITS-1:0] stride_q;
  logic [DIM_BITS-1:0] pitch_q;

  // Walk state: the counters name the copy the next request emits
  logic                busy_q;
  logic                phase_q;
  logic [DIM_BITS-1:0] outer_q;
  logic [DIM_BITS-1:0] inner_q;

  rot_copy_t copies_due[$];
  rot_copy_t got_copy;
  rot_copy_t want_copy;

  initial begin
    fail_count     = 0;
    copies_pending = 0;
  end

  // Loop bounds of one plane, crop rounded down to even, halved for chroma
  function automatic walk_lim_t walk_limits(input logic chroma);
    logic [DIM_BITS-1:0] w;
    logic [DIM_BITS-1:0] h;
    walk_lim_t           lim;
    w = {crop_w_q[DIM_BITS-1:1], 1'b0};
    h = {crop_h_q[DIM_BITS-1:1], 1'b0};
    if (chroma) begin
      w = w >> 1;
      h = h >> 1;
    end
    if (rot_q == ROT_180) begin
      lim.outer_lim = h;
      lim.inner_lim = w;
    end else begin
      lim.outer_lim = w;
      lim.inner_lim = h;
    end
    return lim;
  endfunction

  // Byte offsets of the current copy, worked out wide and wrapped at the end
  function automatic void copy_offsets(output logic [63:0] s, output logic [63:0] d);
    logic [63:0] pw;
    logic [63:0] ph;
    logic [63:0] st;
    logic [63:0] pitch;
    logic [63:0] o;
    logic [63:0] n;
    logic [63:0] unit;
    logic [63:0] cs;
    logic [63:0] pwc;
    logic [63:0] uva;
    logic        planar;
    pw     = 64'({crop_w_q[DIM_BITS-1:1], 1'b0});
    ph     = 64'({crop_h_q[DIM_BITS-1:1], 1'b0});
    st     = 64'(stride_q);
    pitch  = 64'(pitch_q);
    o      = 64'(outer_q);
    n      = 64'(inner_q);
    planar = (layout_q >= LAYOUT_YV12);
    unit   = planar ? 64'd1 : 64'd2;
    cs     = planar ? (st >> 1) : st;
    pwc    = planar ? (pw >> 1) : pw;
    if (phase_q == PLANE_LUMA) begin
      case (rot_q)
        ROT_90: begin
          s = st * n + (pw - 1 - o);
          d = o * pitch + n;
        end
        ROT_180: begin
          s = st * (ph - 1 - o) + (pw - 1 - n);
          d = o * st + n;
        end
        default: begin
          s = st * (ph - 1 - n) + o;
          d = o * pitch + n;
        end
      endcase
    end else begin
      uva = ((rot_q == ROT_180) ? st : pitch) * unit / 2;
      case (rot_q)
        ROT_90:  s = cs * n + pwc - unit * (o + 1);
        ROT_180: s = cs * ((ph >> 1) - 1 - o) + pwc - unit * (n + 1);
        default: s = cs * ((ph >> 1) - 1 - n) + unit * o;
      endcase
      d = o * uva + n * unit;
    end
  endfunction

  // Work out the result of one request and advance the walk
  function automatic rot_copy_t predict_copy(input logic restart);
    rot_copy_t   c;
    walk_lim_t   lim;
    logic [63:0] s;
    logic [63:0] d;
    c        = '0;
    c.status = ST_IDLE;
    if (restart) begin
      if (rot_q == ROT_BAD) begin
        busy_q   = 1'b0;
        c.status = ST_BADROT;
        return c;
      end
      phase_q = PLANE_LUMA;
      outer_q = '0;
      inner_q = '0;
      lim     = walk_limits(PLANE_LUMA);
      busy_q  = (lim.outer_lim != 0) && (lim.inner_lim != 0);
    end else if (busy_q && rot_q == ROT_BAD) begin
      busy_q   = 1'b0;
      c.status = ST_BADROT;
      return c;
    end
    if (!busy_q) return c;

    copy_offsets(s, d);
    c.status = ST_OK;
    c.plane  = phase_q;
    c.src    = s[OFS_BITS-1:0];
    c.dst    = d[OFS_BITS-1:0];

    // Step inner, then outer, then move on to chroma or finish
    lim = walk_limits(phase_q);
    if (32'(inner_q) + 1 < 32'(lim.inner_lim)) begin
      inner_q = inner_q + 1'b1;
    end else begin
      inner_q = '0;
      if (32'(outer_q) + 1 < 32'(lim.outer_lim)) begin
        outer_q = outer_q + 1'b1;
      end else begin
        outer_q = '0;
        lim     = walk_limits(PLANE_CHROMA);
        if (phase_q == PLANE_LUMA && lim.outer_lim != 0 && lim.inner_lim != 0) begin
          phase_q = PLANE_CHROMA;
        end else begin
          busy_q  = 1'b0;
          phase_q = PLANE_LUMA;
          c.last  = 1'b1;
        end
      end
    end
    return c;
  endfunction

  function automatic void flag_copy(input string why, input rot_copy_t want,
                                    input rot_copy_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t %s: expected status %0d plane %0d src %0d dst %0d last %0d, got status %0d plane %0d src %0d dst %0d last %0d",
               $realtime, why, want.status, want.plane, want.src, want.dst, want.last,
               got.status, got.plane, got.src, got.dst, got.last);
  endfunction

  // Compare results, predict requests, track register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      layout_q = '0;
      rot_q    = '0;
      crop_w_q = '0;
      crop_h_q = '0;
      stride_q = '0;
      pitch_q  = '0;
      busy_q   = 1'b0;
      phase_q  = PLANE_LUMA;
      outer_q  = '0;
      inner_q  = '0;
      copies_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        got_copy.status = out_status;
        got_copy.plane  = out_plane;
        got_copy.src    = out_src_offset;
        got_copy.dst    = out_dst_offset;
        got_copy.last   = out_last;
        if (copies_due.size() == 0) begin
          flag_copy("result with no request pending", '0, got_copy);
        end else begin
          want_copy = copies_due.pop_front();
          if (got_copy.status !== want_copy.status || got_copy.plane !== want_copy.plane ||
              got_copy.src !== want_copy.src || got_copy.dst !== want_copy.dst ||
              got_copy.last !== want_copy.last)
            flag_copy("wrong result", want_copy, got_copy);
        end
      end
      if (in_valid && in_ready)
        copies_due.push_back(predict_copy(in_start_req));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LAYOUT:   layout_q = cfg_data[1:0];
          CFG_ROTATION: rot_q    = cfg_data[1:0];
          CFG_CROP_W:   crop_w_q = cfg_data;
          CFG_CROP_H:   crop_h_q = cfg_data;
          CFG_STRIDE:   stride_q = cfg_data;
          CFG_PITCH:    pitch_q  = cfg_data;
          default: ;
        endcase
      end
    end
    copies_pending = copies_due.size();
  end

endmodule

// File: dv/yuv420_rotate_address_generator_test.sv
`timescale 1ns / 100ps

module yuv420_rotate_address_generator_test;

  import yra_pkg::*;

  localparam logic [1:0]              LAYOUT_NV21 = 2'd1;
  localparam logic [1:0]              LAYOUT_YV21 = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED  = 3'd7;
  localparam logic [DIM_BITS-1:0]     DIM_MAX     = '1;

  localparam int RESET_CYCLES = 12;
  localparam int REQ_TARGET   = 1050;
  localparam int SWAP_AT      = 350;
  localparam int QUIET_AT     = 700;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_PAUSE  = 4;
  localparam int RUN_CAP      = 120;
  localparam int QUIET_LIMIT  = 4000;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [DIM_BITS-1:0]     cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_start_req;
  logic                    out_valid;
  logic                    out_ready;
  logic [1:0]              out_status;
  logic                    out_plane;
  logic [OFS_BITS-1:0]     out_src_offset;
  logic [OFS_BITS-1:0]     out_dst_offset;
  logic                    out_last;

  int fail_count;
  int copies_pending;
  int reqs_sent    = 0;
  int snd_idle_pct = 33;
  int rcv_idle_pct = 46;
  int quiet_cycles = 0;
  bit rcv_hold_req = 1'b0;

  // What has been written, for sizing request runs
  logic [DIM_BITS-1:0] crop_w_set = '0;
  logic [DIM_BITS-1:0] crop_h_set = '0;
  logic [1:0]          rot_set    = ROT_90;

  yuv420_rotate_address_generator DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_req   (in_start_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_plane      (out_plane),
    .out_src_offset (out_src_offset),
    .out_dst_offset (out_dst_offset),
    .out_last       (out_last)
  );

  yra_copy_checker copy_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_req   (in_start_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_plane      (out_plane),
    .out_src_offset (out_src_offset),
    .out_dst_offset (out_dst_offset),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .copies_pending (copies_pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random back-pressure, or a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rcv_hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rcv_hold_req = 1'b0;
      end else begin
        out_ready = ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // Abort when nothing moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [DIM_BITS-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    case (idx)
      CFG_ROTATION: rot_set    = data[1:0];
      CFG_CROP_W:   crop_w_set = data;
      CFG_CROP_H:   crop_h_set = data;
      default: ;
    endcase
  endtask

  // Offer one request after a random gap; hold it until accepted
  task automatic send_req(input logic restart);
    while ($urandom_range(0, 99) < snd_idle_pct) @(negedge clk);
    in_start_req = restart;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid     = 1'b0;
    in_start_req = 1'($urandom_range(0, 1));
    reqs_sent++;
    if (reqs_sent == SWAP_AT) begin
      snd_idle_pct = 46;
      rcv_idle_pct = 33;
    end else if (reqs_sent == QUIET_AT) begin
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
    end
  endtask

  // Wait for every result, then let the pipeline settle
  task automatic drain_requests();
    while (copies_pending != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  function automatic int frame_copies();
    int w;
    int h;
    w = int'({crop_w_set[DIM_BITS-1:1], 1'b0});
    h = int'({crop_h_set[DIM_BITS-1:1], 1'b0});
    if (rot_set == ROT_BAD) return 1;
    return w * h + (w / 2) * (h / 2);
  endfunction

  // Mostly small frames, now and then anything up to the full range
  function automatic logic [DIM_BITS-1:0] rand_dim();
    if ($urandom_range(0, 19) == 0) return DIM_BITS'($urandom);
    return DIM_BITS'($urandom_range(0, 10));
  endfunction

  function automatic logic [DIM_BITS-1:0] rand_pitch();
    if ($urandom_range(0, 1) == 0) return DIM_BITS'($urandom);
    return DIM_BITS'($urandom_range(0, 24));
  endfunction

  // Rewrite all registers, or a random subset of them
  task automatic pick_config(input bit every_reg);
    logic [1:0] rot;
    rot = ($urandom_range(0, 9) == 0) ? ROT_BAD : 2'($urandom_range(0, 2));
    if (every_reg || $urandom_range(0, 1)) write_reg(CFG_LAYOUT, DIM_BITS'($urandom));
    if (every_reg || $urandom_range(0, 1)) write_reg(CFG_ROTATION, {11'($urandom), rot});
    if (every_reg || $urandom_range(0, 1)) write_reg(CFG_CROP_W, rand_dim());
    if (every_reg || $urandom_range(0, 1)) write_reg(CFG_CROP_H, rand_dim());
    if (every_reg || $urandom_range(0, 1)) write_reg(CFG_STRIDE, rand_pitch());
    if (every_reg || $urandom_range(0, 1)) write_reg(CFG_PITCH, rand_pitch());
  endtask

  initial begin
    int n;
    bit restart;
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_LAYOUT;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_start_req = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Reset registers: advance while idle, then start an empty frame
    send_req(1'b0);
    send_req(1'b1);

    // Smallest frame, semi-planar at 90 degrees, widest strides, odd width
    drain_requests();
    write_reg(CFG_LAYOUT, LAYOUT_NV12);
    write_reg(CFG_ROTATION, ROT_90);
    write_reg(CFG_CROP_W, 13'd3);
    write_reg(CFG_CROP_H, 13'd2);
    write_reg(CFG_STRIDE, DIM_MAX);
    write_reg(CFG_PITCH, DIM_MAX);
    write_reg(CFG_UNUSED, DIM_MAX);
    send_req(1'b1);
    repeat (5) send_req(1'b0);

    // Bad rotation on a start, then an idle advance
    drain_requests();
    write_reg(CFG_ROTATION, ROT_BAD);
    send_req(1'b1);
    send_req(1'b0);

    // Planar at 270 with zero strides; bad rotation lands mid-frame
    drain_requests();
    write_reg(CFG_LAYOUT, LAYOUT_YV21);
    write_reg(CFG_ROTATION, ROT_270);
    write_reg(CFG_CROP_W, 13'd4);
    write_reg(CFG_CROP_H, 13'd2);
    write_reg(CFG_STRIDE, '0);
    write_reg(CFG_PITCH, '0);
    send_req(1'b1);
    send_req(1'b0);
    send_req(1'b0);
    drain_requests();
    write_reg(CFG_ROTATION, ROT_BAD);
    send_req(1'b0);

    // Height cleared mid-luma: chroma phase is empty and the frame ends early
    drain_requests();
    write_reg(CFG_LAYOUT, LAYOUT_YV12);
    write_reg(CFG_ROTATION, ROT_90);
    write_reg(CFG_CROP_W, 13'd2);
    write_reg(CFG_CROP_H, 13'd2);
    write_reg(CFG_STRIDE, 13'd6);
    write_reg(CFG_PITCH, 13'd4);
    send_req(1'b1);
    drain_requests();
    write_reg(CFG_CROP_H, '0);
    repeat (3) send_req(1'b0);

    // Full-size frame at 180 degrees, restarted part way through
    drain_requests();
    write_reg(CFG_LAYOUT, LAYOUT_NV21);
    write_reg(CFG_ROTATION, ROT_180);
    write_reg(CFG_CROP_W, DIM_MAX);
    write_reg(CFG_CROP_H, DIM_MAX);
    write_reg(CFG_STRIDE, DIM_MAX);
    send_req(1'b1);
    send_req(1'b0);
    send_req(1'b1);
    send_req(1'b0);

    // Long receiver hold-off while requests keep coming
    drain_requests();
    write_reg(CFG_LAYOUT, LAYOUT_NV12);
    write_reg(CFG_ROTATION, ROT_90);
    write_reg(CFG_CROP_W, 13'd8);
    write_reg(CFG_CROP_H, 13'd8);
    write_reg(CFG_STRIDE, 13'd16);
    write_reg(CFG_PITCH, 13'd8);
    rcv_hold_req = 1'b1;
    send_req(1'b1);
    repeat (29) send_req(1'b0);

    // Random runs: mostly whole frames, some continuing after a rewrite
    while (reqs_sent < REQ_TARGET) begin
      drain_requests();
      restart = ($urandom_range(0, 99) < 75);
      pick_config(restart && $urandom_range(0, 1));
      n = restart ? frame_copies() + $urandom_range(0, 2) : $urandom_range(1, 30);
      if (n > RUN_CAP) n = RUN_CAP;
      if (n < 1) n = 1;
      for (int i = 0; i < n; i++)
        send_req((i == 0 && restart) || ($urandom_range(0, 99) < 3));
    end

    drain_requests();
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
